[design/mbps_pkg.sv]
package mbps_pkg;

	localparam int MAX_PATTERN_DEF = 64;
	localparam int OFFSET_BITS_DEF = 32;

	localparam int BYTE_W   = 8;
	localparam int INDEX_W  = 6;
	localparam int LENGTH_W = 7;
	localparam int OUT_OFFSET_W = 32;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_SCAN = 1'b1;

endpackage

[design/mbps_match.sv]
module mbps_match #(
	parameter int MAX_PATTERN = mbps_pkg::MAX_PATTERN_DEF,
	parameter int LEN_W       = $clog2(MAX_PATTERN + 1)
) (
	input  logic [LEN_W-1:0]                                 len,
	input  logic [MAX_PATTERN-1:0][mbps_pkg::BYTE_W-1:0]     pattern,
	input  logic [MAX_PATTERN-1:0]                           care_mask,
	input  logic [MAX_PATTERN-1:0][mbps_pkg::BYTE_W-1:0]     window,
	output logic                                             match
);

	logic [MAX_PATTERN-1:0][mbps_pkg::BYTE_W-1:0] rev_pat;
	logic [MAX_PATTERN-1:0][mbps_pkg::BYTE_W-1:0] aligned_pat;
	logic [MAX_PATTERN-1:0]                       rev_care;
	logic [MAX_PATTERN-1:0]                       aligned_care;
	logic [MAX_PATTERN-1:0]                       pos_ok;
	logic [LEN_W-1:0]                             shift;

	// Window entry k lines up with pattern entry len-1-k: reverse the
	// pattern, then drop the MAX_PATTERN-len unused top entries.
	always_comb begin
		for (int k = 0; k < MAX_PATTERN; k++) begin
			rev_pat[k]  = pattern[MAX_PATTERN-1-k];
			rev_care[k] = care_mask[MAX_PATTERN-1-k];
		end
	end

	assign shift        = LEN_W'(MAX_PATTERN) - len;
	assign aligned_pat  = rev_pat >> (shift * mbps_pkg::BYTE_W);
	assign aligned_care = rev_care >> shift;

	always_comb begin
		for (int k = 0; k < MAX_PATTERN; k++) begin
			pos_ok[k] = (LEN_W'(k) >= len) || !aligned_care[k] ||
				(aligned_pat[k] == window[k]);
		end
	end

	assign match = &pos_ok;

endmodule

[design/masked_byte_pattern_scanner.sv]
// Wildcard byte signature scanner. A load word (command 0) writes one pattern
// byte and its care bit; a scan word (command 1) pushes one buffer byte into a
// sliding window that is compared against every cared pattern position at once.
// A scan word with last set produces one result: found, and the offset of the
// first match start counted from the buffer start (0 when nothing matched); the
// scanner then clears itself for the next buffer. Results pass the input and
// result registers; one word is accepted every cycle unless a result waits on
// out_ready. Pattern alignment shifter and parallel byte compare lie between.
// Offsets saturate at 2^OFFSET_BITS-1 bytes; bytes past that are not searched.
// The user must write pattern_length only while the scanner is idle; unenforced.
module masked_byte_pattern_scanner #(
	parameter int MAX_PATTERN = mbps_pkg::MAX_PATTERN_DEF,
	parameter int OFFSET_BITS = mbps_pkg::OFFSET_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,

	input  logic                                  cfg_wr_en,
	input  logic [mbps_pkg::LENGTH_W-1:0]         cfg_wr_data,

	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic                                  command,
	input  logic [mbps_pkg::INDEX_W-1:0]          pattern_index,
	input  logic [mbps_pkg::BYTE_W-1:0]           pattern_byte,
	input  logic                                  care,
	input  logic [mbps_pkg::BYTE_W-1:0]           data_byte,
	input  logic                                  last,

	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic                                  found,
	output logic [mbps_pkg::OUT_OFFSET_W-1:0]     match_offset
);

	localparam int LEN_W  = $clog2(MAX_PATTERN + 1);
	localparam int CW     = OFFSET_BITS + 1;
	localparam int WIDE_W = (OFFSET_BITS > mbps_pkg::OUT_OFFSET_W) ?
		OFFSET_BITS : mbps_pkg::OUT_OFFSET_W;

	logic [mbps_pkg::LENGTH_W-1:0] pattern_length_q;

	logic                          valid_s1;
	logic                          command_s1;
	logic [mbps_pkg::INDEX_W-1:0]  index_s1;
	logic [mbps_pkg::BYTE_W-1:0]   pbyte_s1;
	logic                          care_s1;
	logic [mbps_pkg::BYTE_W-1:0]   data_s1;
	logic                          last_s1;

	logic [MAX_PATTERN-1:0][mbps_pkg::BYTE_W-1:0] pattern_q;
	logic [MAX_PATTERN-1:0]                       care_q;
	logic [MAX_PATTERN-1:0][mbps_pkg::BYTE_W-1:0] window_q;
	logic [MAX_PATTERN-1:0][mbps_pkg::BYTE_W-1:0] window_next;

	logic [OFFSET_BITS-1:0] count_q;
	logic                   hit_q;
	logic [OFFSET_BITS-1:0] first_off_q;

	logic                          out_valid_q;
	logic                          found_q;
	logic [mbps_pkg::OUT_OFFSET_W-1:0] offset_q;

	logic [8:0]       len_raw;
	logic [LEN_W-1:0] len_eff;
	logic             advance;
	logic             is_scan;
	logic             is_load;
	logic             emit;
	logic             room;
	logic [CW-1:0]    count_inc;
	logic             win_match;
	logic             new_hit;
	logic             hit_next;
	logic [OFFSET_BITS-1:0] off_next;
	logic [WIDE_W-1:0]      off_wide;

	// Effective length: zero acts as one, larger than the store saturates.
	always_comb begin
		len_raw = 9'(pattern_length_q);
		if (len_raw == 9'd0) begin
			len_eff = LEN_W'(1);
		end else if (len_raw > 9'(MAX_PATTERN)) begin
			len_eff = LEN_W'(MAX_PATTERN);
		end else begin
			len_eff = LEN_W'(len_raw);
		end
	end

	assign is_scan = valid_s1 && (command_s1 == mbps_pkg::CMD_SCAN);
	assign is_load = valid_s1 && (command_s1 == mbps_pkg::CMD_LOAD);
	assign emit    = is_scan && last_s1;
	assign advance = valid_s1 && (!emit || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	assign room      = (count_q != {OFFSET_BITS{1'b1}});
	assign count_inc = CW'(count_q) + CW'(1);

	always_comb begin
		window_next[0] = data_s1;
		for (int k = 1; k < MAX_PATTERN; k++) begin
			window_next[k] = window_q[k-1];
		end
	end

	mbps_match #(
		.MAX_PATTERN (MAX_PATTERN),
		.LEN_W       (LEN_W)
	) u_match (
		.len       (len_eff),
		.pattern   (pattern_q),
		.care_mask (care_q),
		.window    (window_next),
		.match     (win_match)
	);

	assign new_hit  = is_scan && room && !hit_q && (count_inc >= CW'(len_eff)) && win_match;
	assign hit_next = hit_q || new_hit;
	assign off_next = new_hit ? OFFSET_BITS'(count_inc - CW'(len_eff)) : first_off_q;
	assign off_wide = WIDE_W'(off_next);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_length_q <= mbps_pkg::LENGTH_W'(1);
		end else if (cfg_wr_en) begin
			pattern_length_q <= cfg_wr_data;
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			command_s1 <= command;
			index_s1   <= pattern_index;
			pbyte_s1   <= pattern_byte;
			care_s1    <= care;
			data_s1    <= data_byte;
			last_s1    <= last;
		end
	end

	// Pattern store: written entry by entry, no reset
	always_ff @(posedge clk) begin
		for (int e = 0; e < MAX_PATTERN; e++) begin
			if (advance && is_load && (9'(index_s1) == 9'(e))) begin
				pattern_q[e] <= pbyte_s1;
				care_q[e]    <= care_s1;
			end
		end
	end

	// Window only holds live bytes once count reaches the length, so no reset
	always_ff @(posedge clk) begin
		if (advance && is_scan && room) begin
			window_q <= window_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			hit_q       <= 1'b0;
			first_off_q <= '0;
		end else if (advance && is_scan) begin
			if (last_s1) begin
				count_q     <= '0;
				hit_q       <= 1'b0;
				first_off_q <= '0;
			end else begin
				if (room) begin
					count_q <= OFFSET_BITS'(count_inc);
				end
				hit_q       <= hit_next;
				first_off_q <= off_next;
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			found_q  <= hit_next;
			offset_q <= hit_next ? off_wide[mbps_pkg::OUT_OFFSET_W-1:0] : '0;
		end
	end

	assign out_valid    = out_valid_q;
	assign found        = found_q;
	assign match_offset = offset_q;

endmodule
